// ===== rtl/core/mekb_pkg.sv =====
`default_nettype none

package mekb_pkg;

  // Default coordinate width of the registers and of the source position fields
  localparam int COORD_WIDTH_DEF = 12;

  // Geometry of one source byte
  localparam int PIXELS_PER_BYTE = 8;
  localparam int LANE_IDX_W      = $clog2(PIXELS_PER_BYTE);
  localparam int PIX_W           = 8;

  // Result side
  localparam int ADDR_W      = 24;
  localparam int OUT_TDATA_W = ((ADDR_W + PIX_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W = 3;

  localparam logic MODE_1BPP = 1'b0;
  localparam logic MODE_8BPP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPP_MODE       = 3'd0,
    REG_KEY_OR_FILL    = 3'd1,
    REG_DEST_X         = 3'd2,
    REG_DEST_Y         = 3'd3,
    REG_SURFACE_WIDTH  = 3'd4,
    REG_SURFACE_HEIGHT = 3'd5,
    REG_SURFACE_PITCH  = 3'd6,
    REG_SOURCE_WIDTH   = 3'd7
  } cfg_reg_t;

  // One source byte after the lanes: which pixels survive and the address parts
  typedef struct packed {
    logic [PIXELS_PER_BYTE-1:0] mask;   // lane 0 is the leftmost pixel
    logic [ADDR_W-1:0]          prod;   // (dest_y + row) * pitch, wrapped
    logic [ADDR_W-1:0]          xbase;  // dest_x + first column of the byte
    logic [PIX_W-1:0]           pixel;
  } blit_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/mekb_lane.sv =====
`default_nettype none

// One pixel position of a source byte: column and clip decision
module mekb_lane #(
  parameter int COORD_WIDTH = mekb_pkg::COORD_WIDTH_DEF,
  parameter int LANE        = 0
) (
  input  logic                   mode,
  input  logic                   pix_bit,
  input  logic                   byte_ne_key,
  input  logic                   row_ok,
  input  logic [COORD_WIDTH-1:0] byte_col,
  input  logic [COORD_WIDTH-1:0] col_limit,
  output logic                   en
);
  import mekb_pkg::*;

  localparam logic [LANE_IDX_W-1:0] K = LANE_IDX_W'(LANE);

  logic [COORD_WIDTH+LANE_IDX_W-1:0] col;
  logic                              hit;

  always_comb begin
    if (mode == MODE_8BPP) begin
      // one pixel per byte, carried by the first lane only
      col = {{LANE_IDX_W{1'b0}}, byte_col};
      hit = (LANE == 0) && byte_ne_key;
    end else begin
      col = {byte_col, K};
      hit = pix_bit;
    end
  end

  assign en = row_ok && hit && (col < {{LANE_IDX_W{1'b0}}, col_limit});

endmodule

`default_nettype wire

// ===== rtl/core/mekb_merge.sv =====
`default_nettype none

// Serialise the surviving lanes of one byte, leftmost first, into an output register
module mekb_merge (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  mekb_pkg::blit_req_t     req,
  output logic                    req_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [mekb_pkg::ADDR_W-1:0] out_address,
  output logic [mekb_pkg::PIX_W-1:0]  out_pixel,
  output logic                    out_last
);
  import mekb_pkg::*;

  logic                       s2_valid;
  blit_req_t                  s2;
  logic [LANE_IDX_W-1:0]      sel;
  logic [PIXELS_PER_BYTE-1:0] sel_hot;
  logic [PIXELS_PER_BYTE-1:0] rest;
  logic                       last;
  logic                       emit;

  // pick the lowest set lane
  always_comb begin
    sel = '0;
    for (int k = PIXELS_PER_BYTE - 1; k >= 0; k--) begin
      if (s2.mask[k]) sel = LANE_IDX_W'(k);
    end
  end

  assign sel_hot   = PIXELS_PER_BYTE'(1) << sel;
  assign rest      = s2.mask & ~sel_hot;
  assign last      = (rest == '0);
  assign emit      = s2_valid && (!out_valid || out_ready);
  assign req_ready = !s2_valid || (emit && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req_ready) s2_valid <= req_valid;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s2 <= req;
    end else if (emit) begin
      s2.mask <= rest;
    end
    if (emit) begin
      out_address <= s2.prod + s2.xbase + ADDR_W'(sel);
      out_pixel   <= s2.pixel;
      out_last    <= last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mono_expand_color_key_blit_top.sv =====
// The first write of a source byte reaches the master side through the input register,
//   the lanes and the row multiply, the serialiser's request register and the output register.
// Throughput: one write per cycle while the master side is ready; a byte with n surviving
//   pixels gives n writes (at most eight in 1bpp, one in 8bpp), a byte with none is dropped.
// Reset: synchronous, active high; clears the configuration registers to 0 and empties
//   the pipeline.
`default_nettype none

module mono_expand_color_key_blit_top #(
  parameter int COORD_WIDTH = mekb_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  // configuration write port
  input  logic                                 cfg_wr_en,
  input  logic [mekb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [((COORD_WIDTH > mekb_pkg::PIX_W) ? COORD_WIDTH : mekb_pkg::PIX_W)-1:0]
                                               cfg_wdata,
  // source bytes
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // source_row, source_column, source_byte, zero pad
  input  logic [((2*COORD_WIDTH + mekb_pkg::PIX_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // surface writes
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // write_address, write_pixel
  output logic [mekb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast     // last_write
);
  import mekb_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int COL_W = CW + LANE_IDX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers; unenforced by the block, the user writes them only while the block is idle
  // ---------------------------------------------------------------------------
  logic                bpp_mode;
  logic [PIX_W-1:0]    key_or_fill;
  logic [CW-1:0]       dest_x;
  logic [CW-1:0]       dest_y;
  logic [CW-1:0]       surface_width;
  logic [CW-1:0]       surface_height;
  logic [CW-1:0]       surface_pitch;
  logic [CW-1:0]       source_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp_mode       <= MODE_1BPP;
      key_or_fill    <= '0;
      dest_x         <= '0;
      dest_y         <= '0;
      surface_width  <= '0;
      surface_height <= '0;
      surface_pitch  <= '0;
      source_width   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BPP_MODE:       bpp_mode       <= cfg_wdata[0];
        REG_KEY_OR_FILL:    key_or_fill    <= cfg_wdata[PIX_W-1:0];
        REG_DEST_X:         dest_x         <= cfg_wdata[CW-1:0];
        REG_DEST_Y:         dest_y         <= cfg_wdata[CW-1:0];
        REG_SURFACE_WIDTH:  surface_width  <= cfg_wdata[CW-1:0];
        REG_SURFACE_HEIGHT: surface_height <= cfg_wdata[CW-1:0];
        REG_SURFACE_PITCH:  surface_pitch  <= cfg_wdata[CW-1:0];
        REG_SOURCE_WIDTH:   source_width   <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: hold one request until its lane result moves on
  // ---------------------------------------------------------------------------
  logic             s1_valid;
  logic [CW-1:0]    s1_row;
  logic [CW-1:0]    s1_col;
  logic [PIX_W-1:0] s1_byte;

  logic             req_valid;
  logic             req_ready;
  blit_req_t        req;
  logic [PIXELS_PER_BYTE-1:0] lane_en;

  // free when empty, when the request yields no write (drop it), or when the
  // serialiser takes it
  assign s_axis_tready = !s1_valid || (lane_en == '0) || req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_row  <= s_axis_tdata[CW-1:0];
      s1_col  <= s_axis_tdata[2*CW-1:CW];
      s1_byte <= s_axis_tdata[2*CW+PIX_W-1:2*CW];
    end
  end

  // ---------------------------------------------------------------------------
  // Clip edges: right and bottom only, an edge left of or above the origin clips all
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_span;
  logic [CW-1:0] col_limit;
  logic [CW-1:0] row_limit;
  logic          row_ok;
  logic          byte_ne_key;

  assign col_span    = (surface_width > dest_x) ? surface_width - dest_x : '0;
  assign col_limit   = (source_width < col_span) ? source_width : col_span;
  assign row_limit   = (surface_height > dest_y) ? surface_height - dest_y : '0;
  assign row_ok      = (s1_row < row_limit);
  assign byte_ne_key = (s1_byte != key_or_fill);

  // ---------------------------------------------------------------------------
  // Lanes: one per pixel of the byte, MSB is lane 0
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < PIXELS_PER_BYTE; k++) begin : g_lane
    mekb_lane #(
      .COORD_WIDTH (CW),
      .LANE        (k)
    ) u_lane (
      .mode        (bpp_mode),
      .pix_bit     (s1_byte[PIX_W-1-k]),
      .byte_ne_key (byte_ne_key),
      .row_ok      (row_ok),
      .byte_col    (s1_col),
      .col_limit   (col_limit),
      .en          (lane_en[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Address parts shared by all lanes; the serialiser adds the lane offset
  // ---------------------------------------------------------------------------
  logic [CW:0]    row_sum;
  logic [2*CW:0]  prod_full;
  logic [COL_W-1:0] col_base;
  logic [COL_W:0] xsum;

  assign row_sum   = {1'b0, dest_y} + {1'b0, s1_row};
  assign prod_full = row_sum * surface_pitch;
  assign col_base  = (bpp_mode == MODE_8BPP) ? {{LANE_IDX_W{1'b0}}, s1_col}
                                             : {s1_col, {LANE_IDX_W{1'b0}}};
  assign xsum      = (COL_W+1)'(dest_x) + (COL_W+1)'(col_base);

  assign req_valid  = s1_valid && (lane_en != '0);
  assign req.mask   = lane_en;
  assign req.prod   = ADDR_W'(prod_full);
  assign req.xbase  = ADDR_W'(xsum);
  assign req.pixel  = (bpp_mode == MODE_8BPP) ? s1_byte : key_or_fill;

  // ---------------------------------------------------------------------------
  // Merge: serialise the surviving pixels onto the master side
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] wr_address;
  logic [PIX_W-1:0]  wr_pixel;

  mekb_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req         (req),
    .req_ready   (req_ready),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_address (wr_address),
    .out_pixel   (wr_pixel),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_W'({wr_pixel, wr_address});

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_out_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("write presented straight after reset");

  a_ready_low_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> s1_valid)
    else $error("input stalled with an empty input register");

  a_held_request_stable: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> s1_valid && $stable(s1_row) && $stable(s1_col)
                                && $stable(s1_byte))
    else $error("stalled request lost or changed");

  a_8bpp_single_lane: assert property (@(posedge clk) disable iff (rst)
    (bpp_mode == MODE_8BPP) && req_valid |-> (req.mask[PIXELS_PER_BYTE-1:1] == '0))
    else $error("8bpp byte produced more than one write");

endmodule

`default_nettype wire

// ===== dv/mono_expand_color_key_blit_top_tb.sv =====
module mono_expand_color_key_blit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mekb_pkg::*;

  localparam int CW           = COORD_WIDTH_DEF;
  localparam int CFG_W        = (CW > PIX_W) ? CW : PIX_W;
  localparam int S_W          = ((2 * CW + PIX_W + 7) / 8) * 8;
  localparam int CORD_MAX     = (1 << CW) - 1;
  localparam int BATCHES      = 8;
  localparam int BATCH_ITEMS  = 32;
  // margin for the pipeline to drain, also after a byte that yields nothing
  localparam int SETTLE_CYCLES = 12;
  // worst case is far below this: ~280 bytes x 8 writes, each behind the longest sink stall
  localparam int CYCLE_LIMIT  = 400000;

  // One surface write as the block should produce it
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
    logic              last;
  } surface_write_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // source_row, source_column, source_byte, zero pad
  logic [S_W-1:0]   s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // write_address, write_pixel
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  // Register image held by the predictor; it tracks every write made to the block
  logic        blit_mode  = MODE_1BPP;
  logic [7:0]  key_fill   = '0;
  int          dest_x     = 0;
  int          dest_y     = 0;
  int          surf_width = 0;
  int          surf_height = 0;
  int          surf_pitch = 0;
  int          src_width  = 0;

  logic [S_W-1:0]  byte_requests_q[$];   // source bytes waiting to be driven
  surface_write_t  surface_writes_q[$];  // writes predicted but not yet seen
  surface_write_t  seen_write;

  int   items_queued = 0;
  int   items_taken  = 0;
  int   mismatches   = 0;
  int   cycle_count  = 0;
  int   src_gap      = 0;
  int   sink_stall   = 0;
  logic src_fire     = 1'b0;
  logic steady_flow  = 1'b0;   // suppress idling on both sides while set

  mono_expand_color_key_blit_top #(
    .COORD_WIDTH(CW)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Visible extent from the destination origin to the clip edge; nothing when
  // the edge lies left of (or above) the origin.
  function automatic int visible_span(input int limit_edge, input int origin);
    return (limit_edge > origin) ? limit_edge - origin : 0;
  endfunction

  function automatic logic [ADDR_W-1:0] write_addr(input int col, input int row);
    int lin;
    lin = (dest_x + col) + (dest_y + row) * surf_pitch;
    return lin[ADDR_W-1:0];
  endfunction

  // Work out the writes one accepted source byte causes and queue them in order.
  task automatic predict_writes(input int row, input int bcol, input logic [7:0] src_byte);
    int             col_lim;
    int             row_lim;
    int             col;
    surface_write_t hits[$];
    surface_write_t w;
    col_lim = visible_span(surf_width, dest_x);
    row_lim = visible_span(surf_height, dest_y);
    if (src_width < col_lim) col_lim = src_width;
    // a row below the bottom edge writes nothing at all
    if (row >= row_lim) return;
    if (blit_mode == MODE_1BPP) begin
      // expand MSB first: bit 7 is the leftmost pixel of the byte
      for (int k = 0; k < PIXELS_PER_BYTE; k++) begin
        col = bcol * PIXELS_PER_BYTE + k;
        if (src_byte[PIXELS_PER_BYTE-1-k] && col < col_lim) begin
          w.addr  = write_addr(col, row);
          w.pixel = key_fill;
          w.last  = 1'b0;
          hits.push_back(w);
        end
      end
    end else if (src_byte != key_fill && bcol < col_lim) begin
      // colour-keyed copy: a pixel equal to the key is transparent
      w.addr  = write_addr(bcol, row);
      w.pixel = src_byte;
      w.last  = 1'b0;
      hits.push_back(w);
    end
    // mark the final write of this byte
    foreach (hits[i]) begin
      hits[i].last = (i == hits.size() - 1);
      surface_writes_q.push_back(hits[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idling helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Coordinate register value biased towards both extremes.
  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return CORD_MAX;
    return $urandom_range(0, CORD_MAX);
  endfunction

  // ---------------------------------------------------------------------------
  // Source driver: present queued requests at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || src_fire) begin
      // slot is free: either idle or the last request was taken at the rising edge
      if (src_gap > 0) begin
        src_gap = src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (byte_requests_q.size() != 0) begin
        s_axis_tdata  <= byte_requests_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (!steady_flow) src_gap = gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink: random back-pressure on the write channel
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall = sink_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady_flow && $urandom_range(0, 3) == 0) sink_stall = gap_len();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    mismatches = mismatches + 1;
    if (mismatches <= 10)
      $display("[%0t] %s: exp addr=%06h pix=%02h last=%0b, got addr=%06h pix=%02h last=%0b",
               $time, what, seen_write.addr, seen_write.pixel, seen_write.last,
               m_axis_tdata[ADDR_W-1:0], m_axis_tdata[ADDR_W+PIX_W-1:ADDR_W], m_axis_tlast);
  endtask

  always @(posedge clk) begin
    src_fire <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      // request taken: predict against the current register image
      predict_writes(int'(s_axis_tdata[CW-1:0]), int'(s_axis_tdata[2*CW-1:CW]),
                     s_axis_tdata[2*CW+PIX_W-1:2*CW]);
      items_taken = items_taken + 1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (surface_writes_q.size() == 0) begin
        seen_write = '0;
        flag_mismatch("write with none expected");
      end else begin
        seen_write = surface_writes_q.pop_front();
        if (seen_write.addr !== m_axis_tdata[ADDR_W-1:0] ||
            seen_write.pixel !== m_axis_tdata[ADDR_W+PIX_W-1:ADDR_W] ||
            seen_write.last !== m_axis_tlast)
          flag_mismatch("write mismatch");
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_byte(input int row, input int bcol, input int src_byte);
    byte_requests_q.push_back({src_byte[PIX_W-1:0], bcol[CW-1:0], row[CW-1:0]});
    items_queued = items_queued + 1;
  endtask

  // Hold until every request is taken and every predicted write is out, then
  // let the pipeline settle so that a byte with no writes has left it too.
  task automatic wait_idle();
    do @(negedge clk);
    while (items_taken != items_queued || surface_writes_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    case (idx)
      REG_BPP_MODE:       blit_mode   = val[0];
      REG_KEY_OR_FILL:    key_fill    = val[7:0];
      REG_DEST_X:         dest_x      = val & CORD_MAX;
      REG_DEST_Y:         dest_y      = val & CORD_MAX;
      REG_SURFACE_WIDTH:  surf_width  = val & CORD_MAX;
      REG_SURFACE_HEIGHT: surf_height = val & CORD_MAX;
      REG_SURFACE_PITCH:  surf_pitch  = val & CORD_MAX;
      REG_SOURCE_WIDTH:   src_width   = val & CORD_MAX;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Program the whole register set; call only while the block is idle.
  task automatic load_setup(input logic mode, input int key, input int dx, input int dy,
                            input int sw, input int sh, input int pitch, input int srcw);
    write_reg(REG_BPP_MODE, int'(mode));
    write_reg(REG_KEY_OR_FILL, key);
    write_reg(REG_DEST_X, dx);
    write_reg(REG_DEST_Y, dy);
    write_reg(REG_SURFACE_WIDTH, sw);
    write_reg(REG_SURFACE_HEIGHT, sh);
    write_reg(REG_SURFACE_PITCH, pitch);
    write_reg(REG_SOURCE_WIDTH, srcw);
  endtask

  initial begin : stimulus
    logic mode;
    int   key, dx, dy, sw, sh, pitch, srcw;
    int   clim, rlim, row, bcol, sb;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Straight out of reset every extent is zero, so everything is clipped.
    queue_byte(0, 0, 8'hFF);
    queue_byte(CORD_MAX, CORD_MAX, 8'hFF);
    wait_idle();

    // Mono expansion: full byte, empty byte, sparse bits, right clip through
    // the middle of a byte, last visible row, first hidden row, far corner.
    load_setup(MODE_1BPP, 8'hA5, 3, 2, 100, 50, 128, 37);
    queue_byte(0, 0, 8'hFF);
    queue_byte(1, 0, 8'h00);
    queue_byte(2, 1, 8'h81);
    queue_byte(3, 4, 8'hFF);
    queue_byte(47, 2, 8'h55);
    queue_byte(48, 0, 8'hFF);
    queue_byte(CORD_MAX, CORD_MAX, 8'hFF);
    queue_byte(5, CORD_MAX, 8'hFF);
    wait_idle();

    // Keyed copy near the bottom-right corner: the largest reachable address,
    // a keyed pixel, a zero pixel and both clip edges.
    load_setup(MODE_8BPP, 8'h5A, 4000, 4000, CORD_MAX, CORD_MAX, CORD_MAX, CORD_MAX);
    queue_byte(94, 94, 8'hFF);
    queue_byte(0, 0, 8'h00);
    queue_byte(0, 1, 8'h5A);
    queue_byte(10, 95, 8'h11);
    queue_byte(95, 3, 8'h22);
    queue_byte(93, 50, 8'hFE);
    wait_idle();

    // Right edge left of the destination: nothing is visible.
    load_setup(MODE_1BPP, 8'hFF, 200, 10, 100, 300, 0, CORD_MAX);
    queue_byte(0, 0, 8'hFF);
    queue_byte(0, 0, 8'hAA);
    wait_idle();

    // Bottom edge above the destination: nothing is visible.
    load_setup(MODE_1BPP, 8'h3C, 0, 500, CORD_MAX, 100, 64, CORD_MAX);
    queue_byte(0, 0, 8'hFF);
    wait_idle();

    // Key of zero: a zero pixel is transparent, the rest is copied.
    load_setup(MODE_8BPP, 8'h00, 0, 0, CORD_MAX, CORD_MAX, CORD_MAX, CORD_MAX);
    queue_byte(0, 0, 8'h00);
    queue_byte(4094, 4094, 8'h80);
    wait_idle();

    // Random batches: fresh geometry per batch, requests mostly aimed at the
    // visible window with some spread over the whole field range.
    for (int batch = 0; batch < BATCHES; batch++) begin
      mode  = 1'($urandom_range(0, 1));
      key   = ($urandom_range(0, 7) == 0) ? 0 :
              ($urandom_range(0, 6) == 0) ? 255 : $urandom_range(0, 255);
      dx    = ($urandom_range(0, 6) == 0) ? pick_coord() : $urandom_range(0, 64);
      dy    = ($urandom_range(0, 6) == 0) ? pick_coord() : $urandom_range(0, 64);
      sw    = ($urandom_range(0, 6) == 0) ? pick_coord() : dx + $urandom_range(0, 400);
      sh    = ($urandom_range(0, 6) == 0) ? pick_coord() : dy + $urandom_range(0, 300);
      if (sw > CORD_MAX) sw = CORD_MAX;
      if (sh > CORD_MAX) sh = CORD_MAX;
      pitch = pick_coord();
      srcw  = ($urandom_range(0, 6) == 0) ? pick_coord() : $urandom_range(1, 256);
      load_setup(mode, key, dx, dy, sw, sh, pitch, srcw);

      // one batch runs with no idling on either side
      steady_flow = (batch == 2);

      clim = visible_span(sw, dx);
      if (srcw < clim) clim = srcw;
      rlim = visible_span(sh, dy);

      for (int n = 0; n < BATCH_ITEMS; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          row  = $urandom_range(0, CORD_MAX);
          bcol = $urandom_range(0, CORD_MAX);
        end else begin
          row  = $urandom_range(0, (rlim + 1 > CORD_MAX) ? CORD_MAX : rlim + 1);
          bcol = (mode == MODE_1BPP) ? $urandom_range(0, clim / PIXELS_PER_BYTE + 1)
                                     : $urandom_range(0, (clim + 1 > CORD_MAX) ?
                                                         CORD_MAX : clim + 1);
        end
        sb = (mode == MODE_8BPP && $urandom_range(0, 5) == 0) ? key : $urandom_range(0, 255);
        queue_byte(row, bcol, sb);
        // halfway through one batch, hold the source until all writes are out
        if (batch == 1 && n == BATCH_ITEMS / 2) wait_idle();
      end
      wait_idle();
    end
    steady_flow = 1'b0;

    if (mismatches == 0 && surface_writes_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mekb_pkg.sv
rtl/core/mekb_lane.sv
rtl/core/mekb_merge.sv
rtl/core/mono_expand_color_key_blit_top.sv
dv/mono_expand_color_key_blit_top_tb.sv
